// ===== rtl/core/pnoise_pkg.sv =====
// Shared constants, widths and the gradient sine table for the 2D gradient noise block.
package pnoise_pkg;

    localparam int COORD_FRAC_BITS  = 16;
    localparam int OUT_FRAC_BITS    = 15;
    localparam int ANGLE_TABLE_BITS = 10;
    localparam int MID_FRAC         = 16;

    localparam logic [31:0] HASH_K1 = 32'd3284157443;
    localparam logic [31:0] HASH_K2 = 32'd1911520717;
    localparam logic [31:0] HASH_K3 = 32'd2048419325;

    // odd degree-9 sine polynomial coefficients, Q28
    localparam longint SC1 = 421657428;
    localparam longint SC3 = 173399667;
    localparam longint SC5 = 21392326;
    localparam longint SC7 = 1256747;
    localparam longint SC9 = 43068;

    localparam int CORNER_W = 33 - COORD_FRAC_BITS;
    localparam int FRAC_W   = COORD_FRAC_BITS + 2;
    localparam int WGT_W    = COORD_FRAC_BITS + 3;
    localparam int SINE_W   = 16;
    localparam int PROD_W   = FRAC_W + SINE_W;
    localparam int DOT_SH   = COORD_FRAC_BITS + 15 - MID_FRAC;
    localparam int DOT_W    = MID_FRAC + 4;
    localparam int MIX_W    = DOT_W + 4;
    localparam int VAL_W    = MIX_W + 4;
    localparam int RND_SH   = MID_FRAC - OUT_FRAC_BITS;
    localparam int LATENCY  = 12;

    localparam logic signed [VAL_W:0] SAT_HI = (VAL_W + 1)'(32767);
    localparam logic signed [VAL_W:0] SAT_LO = (VAL_W + 1)'(-32768);

    localparam int QTR_W     = ANGLE_TABLE_BITS - 2;
    localparam int Q_ENTRIES = 1 << QTR_W;

    typedef logic [14:0] t_sine_tbl [Q_ENTRIES];

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    // sine magnitude of a Q14 quarter-turn position, Q1.15, capped
    function automatic logic [14:0] sine_mag(input int t);
        longint tt;
        longint t2;
        longint p;
        longint m;
        tt = longint'(t);
        t2 = (tt * tt) >>> 14;
        p  = SC9;
        p  = SC7 - ((p * t2) >>> 14);
        p  = SC5 - ((p * t2) >>> 14);
        p  = SC3 - ((p * t2) >>> 14);
        p  = SC1 - ((p * t2) >>> 14);
        m  = (p * tt) >>> 14;
        m  = (m + 4096) >>> 13;
        if (m > 32767) m = 32767;
        return 15'(m);
    endfunction

    function automatic t_sine_tbl build_sine_tbl();
        t_sine_tbl tbl;
        for (int i = 0; i < Q_ENTRIES; i++) begin
            tbl[i] = sine_mag(i << (16 - ANGLE_TABLE_BITS));
        end
        return tbl;
    endfunction

    localparam t_sine_tbl   SINE_TBL  = build_sine_tbl();
    localparam logic [14:0] SINE_PEAK = sine_mag(16384);

    // signed sine of quadrant q, quarter index qi
    function automatic logic signed [SINE_W-1:0] grad_sine(input logic [1:0] q,
                                                           input logic [QTR_W-1:0] qi);
        logic [14:0]      mag;
        logic [QTR_W-1:0] j;
        j = QTR_W'(0) - qi;
        if (q[0]) begin
            mag = (qi == '0) ? SINE_PEAK : SINE_TBL[j];
        end else begin
            mag = SINE_TBL[qi];
        end
        return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ===== rtl/core/pnoise_hash.sv =====
// Three-stage corner hash giving the top angle bits of one cell corner.
module pnoise_hash (
    input  logic                                  i_clk,
    input  pnoise_pkg::t_pipe_ctl                 i_ctl,
    input  logic [31:0]                           i_cx,
    input  logic [31:0]                           i_cz,
    output logic [pnoise_pkg::ANGLE_TABLE_BITS-1:0] o_angle
);
    logic [31:0] r_a1, r_cz1, r_a2, r_b2;
    logic [31:0] n_b2, n_h3;
    logic [pnoise_pkg::ANGLE_TABLE_BITS-1:0] r_angle;

    always_comb begin
        n_b2 = (r_cz1 ^ {r_a1[15:0], r_a1[31:16]}) * pnoise_pkg::HASH_K2;
        n_h3 = (r_a2 ^ {r_b2[15:0], r_b2[31:16]}) * pnoise_pkg::HASH_K3;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a1    <= i_cx * pnoise_pkg::HASH_K1;
            r_cz1   <= i_cz;
            r_b2    <= n_b2;
            r_a2    <= r_a1;
            r_angle <= n_h3[31 -: pnoise_pkg::ANGLE_TABLE_BITS];
        end
    end

    assign o_angle = r_angle;
endmodule

// ===== rtl/core/pnoise_dot.sv =====
// Gradient lookup and dot product with the corner offset, three stages.
module pnoise_dot (
    input  logic                                    i_clk,
    input  pnoise_pkg::t_pipe_ctl                   i_ctl,
    input  logic [pnoise_pkg::ANGLE_TABLE_BITS-1:0] i_angle,
    input  logic signed [pnoise_pkg::FRAC_W-1:0]    i_dx,
    input  logic signed [pnoise_pkg::FRAC_W-1:0]    i_dz,
    output logic signed [pnoise_pkg::DOT_W-1:0]     o_dot
);
    logic signed [pnoise_pkg::SINE_W-1:0] r_gx, r_gz;
    logic signed [pnoise_pkg::FRAC_W-1:0] r_dx, r_dz;
    logic signed [pnoise_pkg::PROD_W-1:0] r_px, r_pz;
    logic signed [pnoise_pkg::PROD_W:0]   n_sum;
    logic signed [pnoise_pkg::DOT_W-1:0]  r_dot;
    logic [1:0]                           w_q;
    logic [pnoise_pkg::QTR_W-1:0]         w_qi;

    assign w_q  = i_angle[pnoise_pkg::ANGLE_TABLE_BITS-1 -: 2];
    assign w_qi = i_angle[pnoise_pkg::QTR_W-1:0];

    always_comb begin
        n_sum = (pnoise_pkg::PROD_W + 1)'(r_px) + (pnoise_pkg::PROD_W + 1)'(r_pz);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // cosine is the sine a quarter turn on
            r_gx  <= pnoise_pkg::grad_sine(w_q, w_qi);
            r_gz  <= pnoise_pkg::grad_sine(w_q + 2'd1, w_qi);
            r_dx  <= i_dx;
            r_dz  <= i_dz;
            r_px  <= r_dx * r_gx;
            r_pz  <= r_dz * r_gz;
            r_dot <= pnoise_pkg::DOT_W'(n_sum >>> pnoise_pkg::DOT_SH);
        end
    end

    assign o_dot = r_dot;
endmodule

// ===== rtl/core/pnoise_mix.sv =====
// Smoothstep blend of four corner dots, rounding and saturation, five stages.
module pnoise_mix (
    input  logic                                 i_clk,
    input  pnoise_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [pnoise_pkg::DOT_W-1:0]  i_d00,
    input  logic signed [pnoise_pkg::DOT_W-1:0]  i_d10,
    input  logic signed [pnoise_pkg::DOT_W-1:0]  i_d01,
    input  logic signed [pnoise_pkg::DOT_W-1:0]  i_d11,
    input  logic [pnoise_pkg::WGT_W-1:0]         i_wx,
    input  logic [pnoise_pkg::WGT_W-1:0]         i_wz,
    output logic signed [15:0]                   o_noise
);
    localparam int F = pnoise_pkg::COORD_FRAC_BITS;
    localparam int D = pnoise_pkg::DOT_W;
    localparam int M = pnoise_pkg::MIX_W;
    localparam int V = pnoise_pkg::VAL_W;
    localparam int W = pnoise_pkg::WGT_W;

    logic signed [D:0]       n_dt, n_db;
    logic signed [W:0]       w_wxs, w_wzs;
    logic signed [D+W+1:0]   r_pt, r_pb;
    logic signed [D-1:0]     r_t0, r_b0;
    logic [W-1:0]            r_wz_g, r_wz_h;
    logic signed [M-1:0]     r_top, r_bot, r_top_i;
    logic signed [M:0]       n_dv;
    logic signed [M+W+1:0]   r_pv;
    logic signed [V-1:0]     r_v;
    logic signed [V:0]       n_sum, n_rnd;
    logic signed [15:0]      r_noise;

    always_comb begin
        w_wxs = $signed({1'b0, i_wx});
        w_wzs = $signed({1'b0, r_wz_h});
        n_dt  = (D + 1)'(i_d10) - (D + 1)'(i_d00);
        n_db  = (D + 1)'(i_d11) - (D + 1)'(i_d01);
        n_dv  = (M + 1)'(r_bot) - (M + 1)'(r_top);
        n_sum = (V + 1)'(r_v) + (V + 1)'(1 << (pnoise_pkg::RND_SH - 1));
        n_rnd = n_sum >>> pnoise_pkg::RND_SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pt    <= n_dt * w_wxs;
            r_pb    <= n_db * w_wxs;
            r_t0    <= i_d00;
            r_b0    <= i_d01;
            r_wz_g  <= i_wz;
            r_top   <= M'(r_t0) + M'(r_pt >>> F);
            r_bot   <= M'(r_b0) + M'(r_pb >>> F);
            r_wz_h  <= r_wz_g;
            r_pv    <= n_dv * w_wzs;
            r_top_i <= r_top;
            r_v     <= V'(r_top_i) + V'(r_pv >>> F);
            if (n_rnd > pnoise_pkg::SAT_HI) begin
                r_noise <= 16'sh7FFF;
            end else if (n_rnd < pnoise_pkg::SAT_LO) begin
                r_noise <= -16'sh8000;
            end else begin
                r_noise <= 16'(n_rnd);
            end
        end
    end

    assign o_noise = r_noise;
endmodule

// ===== rtl/core/perlin_noise_2d_hashed_gradient.sv =====
// Top level of the 2D hashed-gradient noise pipeline.
// One sample point (x, z) in signed Q16.16 goes in per word and one Q1.15 noise
// word comes out for it; a new point is taken each cycle unless output stalls. The
// first stage splits each coordinate into a cell corner, truncated toward zero,
// and a signed fraction. The four corners are then hashed through three chained
// 32-bit multiplies (one per stage) while the smoothstep weights are built in
// parallel; gradient lookup and dot product take three more stages, and the two
// blends, rounding and saturation take the last five. The whole pipeline holds
// as one while a finished word waits on the output side, so a stall drops and
// repeats nothing; input ready is simply "output empty or being taken".
module perlin_noise_2d_hashed_gradient (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_z_coord,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value
);
    localparam int F = pnoise_pkg::COORD_FRAC_BITS;
    localparam int C = pnoise_pkg::CORNER_W;
    localparam int R = pnoise_pkg::FRAC_W;
    localparam int W = pnoise_pkg::WGT_W;
    localparam int L = pnoise_pkg::LATENCY;

    pnoise_pkg::t_pipe_ctl w_ctl;
    logic [L-1:0]          r_vld;

    // stage 1: cell corners and fractions
    logic signed [31-F:0]  w_flx, w_flz;
    logic                  w_adjx, w_adjz;
    logic signed [C-1:0]   r_x0, r_x1, r_z0, r_z1;
    logic signed [R-1:0]   r_sx_d [4];
    logic signed [R-1:0]   r_sz_d [4];

    // weight stages
    logic signed [2*R-1:0] r_sqx, r_sqz;
    logic [F+3:0]          n_kx, n_kz;
    logic [2*F+2:0]        r_kwx, r_kwz;
    logic [W-1:0]          r_wx_d [4];
    logic [W-1:0]          r_wz_d [4];

    logic [pnoise_pkg::ANGLE_TABLE_BITS-1:0] w_ang [4];
    logic signed [pnoise_pkg::DOT_W-1:0]     w_dot [4];
    logic signed [R-1:0]                     w_dx0, w_dx1, w_dz0, w_dz1;

    // advance whenever the output word is empty or being taken
    assign w_ctl.en = !r_vld[L-1] || i_ready;
    assign o_ready  = w_ctl.en;
    assign o_valid  = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ctl.en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_comb begin
        w_flx  = (32 - F)'(i_x_coord >>> F);
        w_flz  = (32 - F)'(i_z_coord >>> F);
        // negative with a fraction: step the floor back up toward zero
        w_adjx = i_x_coord[31] && (i_x_coord[F-1:0] != '0);
        w_adjz = i_z_coord[31] && (i_z_coord[F-1:0] != '0);
        n_kx   = (F + 4)'(3 << F) - (F + 4)'({r_sx_d[1], 1'b0});
        n_kz   = (F + 4)'(3 << F) - (F + 4)'({r_sz_d[1], 1'b0});
        w_dx0  = r_sx_d[3];
        w_dz0  = r_sz_d[3];
        w_dx1  = r_sx_d[3] - R'(1 << F);
        w_dz1  = r_sz_d[3] - R'(1 << F);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en) begin
            r_x0 <= C'(w_flx) + C'({1'b0, w_adjx});
            r_x1 <= C'(w_flx) + C'({1'b0, w_adjx}) + C'(1);
            r_z0 <= C'(w_flz) + C'({1'b0, w_adjz});
            r_z1 <= C'(w_flz) + C'({1'b0, w_adjz}) + C'(1);
            r_sx_d[0] <= {{2{w_adjx}}, i_x_coord[F-1:0]};
            r_sz_d[0] <= {{2{w_adjz}}, i_z_coord[F-1:0]};
            for (int i = 1; i < 4; i++) begin
                r_sx_d[i] <= r_sx_d[i-1];
                r_sz_d[i] <= r_sz_d[i-1];
            end
            // smoothstep (3 - 2w) w^2, truncated at each step
            r_sqx <= r_sx_d[0] * r_sx_d[0];
            r_sqz <= r_sz_d[0] * r_sz_d[0];
            r_kwx <= (2*F + 3)'(n_kx[F+2:0]) * (2*F + 3)'(r_sqx[2*F-1:F]);
            r_kwz <= (2*F + 3)'(n_kz[F+2:0]) * (2*F + 3)'(r_sqz[2*F-1:F]);
            r_wx_d[0] <= r_kwx[2*F+2:F];
            r_wz_d[0] <= r_kwz[2*F+2:F];
            for (int i = 1; i < 4; i++) begin
                r_wx_d[i] <= r_wx_d[i-1];
                r_wz_d[i] <= r_wz_d[i-1];
            end
        end
    end

    // corners in order: (x0,z0) (x1,z0) (x0,z1) (x1,z1)
    pnoise_hash u_hash00 (.i_clk(i_clk), .i_ctl(w_ctl), .i_cx(32'(r_x0)),
                          .i_cz(32'(r_z0)), .o_angle(w_ang[0]));
    pnoise_hash u_hash10 (.i_clk(i_clk), .i_ctl(w_ctl), .i_cx(32'(r_x1)),
                          .i_cz(32'(r_z0)), .o_angle(w_ang[1]));
    pnoise_hash u_hash01 (.i_clk(i_clk), .i_ctl(w_ctl), .i_cx(32'(r_x0)),
                          .i_cz(32'(r_z1)), .o_angle(w_ang[2]));
    pnoise_hash u_hash11 (.i_clk(i_clk), .i_ctl(w_ctl), .i_cx(32'(r_x1)),
                          .i_cz(32'(r_z1)), .o_angle(w_ang[3]));

    pnoise_dot u_dot00 (.i_clk(i_clk), .i_ctl(w_ctl), .i_angle(w_ang[0]),
                        .i_dx(w_dx0), .i_dz(w_dz0), .o_dot(w_dot[0]));
    pnoise_dot u_dot10 (.i_clk(i_clk), .i_ctl(w_ctl), .i_angle(w_ang[1]),
                        .i_dx(w_dx1), .i_dz(w_dz0), .o_dot(w_dot[1]));
    pnoise_dot u_dot01 (.i_clk(i_clk), .i_ctl(w_ctl), .i_angle(w_ang[2]),
                        .i_dx(w_dx0), .i_dz(w_dz1), .o_dot(w_dot[2]));
    pnoise_dot u_dot11 (.i_clk(i_clk), .i_ctl(w_ctl), .i_angle(w_ang[3]),
                        .i_dx(w_dx1), .i_dz(w_dz1), .o_dot(w_dot[3]));

    pnoise_mix u_mix (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_d00   (w_dot[0]),
        .i_d10   (w_dot[1]),
        .i_d01   (w_dot[2]),
        .i_d11   (w_dot[3]),
        .i_wx    (r_wx_d[3]),
        .i_wz    (r_wz_d[3]),
        .o_noise (o_noise_value)
    );
endmodule

// ===== rtl/core/pnoise_checker.sv =====
// Port-level checks on the noise pipeline, bound to the top level.
module pnoise_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_noise_value
);
    // a waiting output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("output word changed while stalled");

    // input side advances exactly when the output word can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready disagrees with output stall");

    // reset drains the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind perlin_noise_2d_hashed_gradient pnoise_checker u_pnoise_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_noise_value (o_noise_value)
);

// ===== tb/perlin_noise_2d_hashed_gradient_tb.sv =====
// Self-checking testbench for the 2D hashed-gradient noise pipeline.
`timescale 1ns / 100ps

module perlin_noise_2d_hashed_gradient_tb;
    import pnoise_pkg::*;

    // Noise scoreboard: predict each accepted sample, hold the noise words still owed.
    class noise_scoreboard;
        logic signed [15:0] owed_noise_q[$];
        int                 fail_count;

        function new();
            fail_count = 0;
        endfunction

        // sine of a 16-bit phase, one turn = 65536, Q1.15
        function longint phase_sin(logic [15:0] ph);
            logic [1:0] quad;
            longint     t;
            longint     t2;
            longint     poly;
            longint     mag;
            quad = ph[15:14];
            t    = quad[0] ? (16384 - longint'(ph[13:0])) : longint'(ph[13:0]);
            t2   = (t * t) >>> 14;
            poly = SC9;
            poly = SC7 - ((poly * t2) >>> 14);
            poly = SC5 - ((poly * t2) >>> 14);
            poly = SC3 - ((poly * t2) >>> 14);
            poly = SC1 - ((poly * t2) >>> 14);
            mag  = (poly * t) >>> 14;
            mag  = (mag + 4096) >>> 13;
            if (mag > 32767) mag = 32767;
            return quad[1] ? -mag : mag;
        endfunction

        // hash a corner to a gradient and dot it with the offset to the point, Q16
        function longint gradient_dot(longint cx, longint cz, longint xs, longint zs);
            logic [31:0] ha;
            logic [31:0] hb;
            logic [15:0] ph;
            longint      gx;
            longint      gz;
            longint      dx;
            longint      dz;
            ha = cx[31:0];
            hb = cz[31:0];
            ha = ha * HASH_K1;
            hb = hb ^ {ha[15:0], ha[31:16]};
            hb = hb * HASH_K2;
            ha = ha ^ {hb[15:0], hb[31:16]};
            ha = ha * HASH_K3;
            ph = 16'(ha >> (32 - ANGLE_TABLE_BITS)) << (16 - ANGLE_TABLE_BITS);
            gx = phase_sin(ph);
            gz = phase_sin(ph + 16'h4000);
            dx = xs - (cx <<< COORD_FRAC_BITS);
            dz = zs - (cz <<< COORD_FRAC_BITS);
            return (dx * gx + dz * gz) >>> (COORD_FRAC_BITS + 15 - MID_FRAC);
        endfunction

        // integer part, truncated toward zero
        function longint cell_of(longint v);
            if (v >= 0) return v >>> COORD_FRAC_BITS;
            return -((-v) >>> COORD_FRAC_BITS);
        endfunction

        // smoothstep (3-2w)w^2 in the coordinate format
        function longint fade(longint w);
            longint w2;
            longint k;
            w2 = (w * w) >>> COORD_FRAC_BITS;
            k  = 3 * (longint'(1) <<< COORD_FRAC_BITS) - 2 * w;
            return (k * w2) >>> COORD_FRAC_BITS;
        endfunction

        function longint lerp(longint a0, longint a1, longint s);
            return a0 + (((a1 - a0) * s) >>> COORD_FRAC_BITS);
        endfunction

        function logic signed [15:0] noise_at(logic signed [31:0] x, logic signed [31:0] z);
            longint xs;
            longint zs;
            longint x0;
            longint z0;
            longint wx;
            longint wz;
            longint top_row;
            longint bot_row;
            longint mixed;
            xs = x;
            zs = z;
            x0 = cell_of(xs);
            z0 = cell_of(zs);
            wx = fade(xs - (x0 <<< COORD_FRAC_BITS));
            wz = fade(zs - (z0 <<< COORD_FRAC_BITS));
            top_row = lerp(gradient_dot(x0, z0, xs, zs), gradient_dot(x0 + 1, z0, xs, zs), wx);
            bot_row = lerp(gradient_dot(x0, z0 + 1, xs, zs),
                           gradient_dot(x0 + 1, z0 + 1, xs, zs), wx);
            mixed = lerp(top_row, bot_row, wz);
            // round half up to the output format, then saturate
            if (MID_FRAC > OUT_FRAC_BITS)
                mixed = (mixed + (longint'(1) <<< (MID_FRAC - OUT_FRAC_BITS - 1)))
                        >>> (MID_FRAC - OUT_FRAC_BITS);
            if (mixed > 32767) mixed = 32767;
            if (mixed < -32768) mixed = -32768;
            return 16'(mixed);
        endfunction

        function void note_sample(logic signed [31:0] x, logic signed [31:0] z);
            owed_noise_q.push_back(noise_at(x, z));
        endfunction

        function void check_word(logic signed [15:0] got);
            logic signed [15:0] want;
            if (owed_noise_q.size() == 0) begin
                $error("noise_value: unexpected word, actual %0d", got);
                fail_count++;
                return;
            end
            want = owed_noise_q.pop_front();
            if (got !== want) begin
                $error("noise_value: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        endfunction

        function int owed();
            return owed_noise_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_z_coord;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_noise_value;

    noise_scoreboard sb;

    // idle rates in percent, and a long receiver hold-off counted in its own process
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_left;

    perlin_noise_2d_hashed_gradient dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_coord    (i_x_coord),
        .i_z_coord    (i_z_coord),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_noise_value(o_noise_value)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: drop ready at random, or for the whole of a hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_left != 0) begin
            i_ready       <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check output words mid-cycle, where every signal has settled.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_word(o_noise_value);
    end

    // Offer one sample; hold it until the handshake edge, then note it.
    task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            i_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_z_coord <= z;
        do @(negedge i_clk); while (!o_ready);
        sb.note_sample(x, z);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge i_clk);
    endtask

    // Random point: small grids near the origin, full range, cell edges, or mid-range x.
    task automatic send_random(input int count);
        logic signed [31:0] x;
        logic signed [31:0] z;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: begin
                    x = $urandom;
                    z = $urandom;
                end
                1: begin
                    x = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
                    z = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
                end
                2: begin
                    x = {16'($urandom_range(16'hFFFF)), 16'h0000}
                        + 32'($urandom_range(2)) - 32'd1;
                    z = {16'($urandom_range(16'hFFFF)), 16'hFFFF}
                        + 32'($urandom_range(2));
                end
                default: begin
                    x = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
                    z = $urandom;
                end
            endcase
            send_sample(x, z);
        end
    endtask

    initial begin
        logic signed [31:0] corner_pts[12];
        sb            = new();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_x_coord     <= '0;
        i_z_coord     <= '0;
        send_idle_pct = 10;
        recv_idle_pct = 75;
        hold_off_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: origin, extremes, both sides of zero, whole and half cells.
        corner_pts = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
                       32'sh0000_FFFF, 32'shFFFF_0001, 32'sh0001_0000, 32'shFFFF_0000,
                       32'sh0000_8000, 32'shFFFF_8000, 32'sh7FFF_0000, 32'sh8000_0001};
        for (int k = 0; k < 12; k++) send_sample(corner_pts[k], corner_pts[(k * 5 + 3) % 12]);
        for (int k = 0; k < 8; k++) send_sample(corner_pts[k + 4], corner_pts[k]);

        send_random(360);

        // Hold the receiver off long enough that the pipeline fills and stalls input.
        hold_off_left = 200;
        send_random(30);

        // Pause the sender until every owed word has come.
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 10;
        send_random(360);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(360);

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
